@@ src/bmpq_pkg.sv @@
`timescale 1ns / 1ps

package bmpq_pkg;

	// Number of nodes and of buckets; node and key fields are ten bits wide.
	localparam int NODES = 1024;
	localparam int NW    = $clog2(NODES);
	localparam int LW    = NW + 1;
	localparam logic [LW-1:0] NIL = LW'(NODES);

	localparam int ACT_W  = 3;
	localparam int IN_W   = 24;
	localparam int OUT_W  = 64;

	// Action codes.
	localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd1;
	localparam logic [ACT_W-1:0] ACT_CHANGE = 3'd2;
	localparam logic [ACT_W-1:0] ACT_POP    = 3'd3;
	localparam logic [ACT_W-1:0] ACT_QUERY  = 3'd4;

	// One node entry: key, list links and presence flag.
	typedef struct packed {
		logic [NW-1:0] key;
		logic [LW-1:0] prev;
		logic [LW-1:0] next;
		logic          present;
	} node_ent_t;

	typedef struct packed {
		logic          en;
		logic [NW-1:0] addr;
	} mem_rd_t;

	typedef struct packed {
		logic          we_key;
		logic          we_prev;
		logic          we_next;
		logic          we_pres;
		logic [NW-1:0] addr;
		node_ent_t     data;
	} node_wr_t;

	// One bucket entry: list head and node count.
	typedef struct packed {
		logic [LW-1:0] head;
		logic [LW-1:0] cnt;
	} bkt_ent_t;

	typedef struct packed {
		logic          we_head;
		logic          we_cnt;
		logic [NW-1:0] addr;
		bkt_ent_t      data;
	} bkt_wr_t;

endpackage

@@ src/bmpq_node_mem.sv @@
`timescale 1ns / 1ps

module bmpq_node_mem (
	input  logic                clk,
	input  bmpq_pkg::mem_rd_t   rd,
	input  bmpq_pkg::node_wr_t  wr,
	output bmpq_pkg::node_ent_t rdata
);

	bmpq_pkg::node_ent_t mem [bmpq_pkg::NODES];

	// Field-masked write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr.we_key) begin
			mem[wr.addr].key <= wr.data.key;
		end
		if (wr.we_prev) begin
			mem[wr.addr].prev <= wr.data.prev;
		end
		if (wr.we_next) begin
			mem[wr.addr].next <= wr.data.next;
		end
		if (wr.we_pres) begin
			mem[wr.addr].present <= wr.data.present;
		end
		if (rd.en) begin
			rdata <= mem[rd.addr];
		end
	end

endmodule

@@ src/bmpq_bkt_mem.sv @@
`timescale 1ns / 1ps

module bmpq_bkt_mem (
	input  logic               clk,
	input  bmpq_pkg::mem_rd_t  rd,
	input  bmpq_pkg::bkt_wr_t  wr,
	output bmpq_pkg::bkt_ent_t rdata
);

	bmpq_pkg::bkt_ent_t mem [bmpq_pkg::NODES];

	// Field-masked write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr.we_head) begin
			mem[wr.addr].head <= wr.data.head;
		end
		if (wr.we_cnt) begin
			mem[wr.addr].cnt <= wr.data.cnt;
		end
		if (rd.en) begin
			rdata <= mem[rd.addr];
		end
	end

endmodule

@@ src/bmpq_ctrl.sv @@
`timescale 1ns / 1ps

module bmpq_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [bmpq_pkg::IN_W-1:0]        s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [bmpq_pkg::OUT_W-1:0]       m_tdata,
	output bmpq_pkg::mem_rd_t                node_rd,
	output bmpq_pkg::node_wr_t               node_wr,
	input  bmpq_pkg::node_ent_t              node_rdata,
	output bmpq_pkg::mem_rd_t                bkt_rd,
	output bmpq_pkg::bkt_wr_t                bkt_wr,
	input  bmpq_pkg::bkt_ent_t               bkt_rdata
);

	localparam int NW = bmpq_pkg::NW;
	localparam int LW = bmpq_pkg::LW;

	typedef enum logic [14:0] {
		ST_CLR  = 15'b000000000000001,
		ST_IDLE = 15'b000000000000010,
		ST_NCHK = 15'b000000000000100,
		ST_U2   = 15'b000000000001000,
		ST_U3   = 15'b000000000010000,
		ST_SRD  = 15'b000000000100000,
		ST_SCK  = 15'b000000001000000,
		ST_L0   = 15'b000000010000000,
		ST_L1   = 15'b000000100000000,
		ST_L2   = 15'b000001000000000,
		ST_PHD  = 15'b000010000000000,
		ST_FIN0 = 15'b000100000000000,
		ST_FIN1 = 15'b001000000000000,
		ST_FIN2 = 15'b010000000000000,
		ST_FOUT = 15'b100000000000000
	} state_t;

	state_t state_q;

	logic [bmpq_pkg::ACT_W-1:0] op_q;
	logic [NW-1:0] n_q, kin_q, uk_q, rnode_q, rkey_q, qkey_q, tnode_q, tkey_q;
	logic [LW-1:0] p_q, x_q, h_q, b_q, total_q, low_q;
	logic          status_q, tval_q, cnt0_q, ovalid_q;
	logic [bmpq_pkg::OUT_W-1:0] out_q;

	logic [bmpq_pkg::ACT_W-1:0] in_act;
	logic [NW-1:0] in_node, in_key;
	logic          n_ok, k_ok, q_nonempty;
	logic [LW-1:0] newcnt;

	assign in_act  = s_tdata[2:0];
	assign in_node = s_tdata[12:3];
	assign in_key  = s_tdata[22:13];
	assign n_ok    = {1'b0, in_node} < bmpq_pkg::NIL;
	assign k_ok    = {1'b0, in_key} < bmpq_pkg::NIL;
	assign q_nonempty = (total_q != '0) && (low_q != bmpq_pkg::NIL);
	assign newcnt  = (bkt_rdata.cnt != '0) ? bkt_rdata.cnt - LW'(1) : '0;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = ovalid_q;
	assign m_tdata  = out_q;

	// Memory requests issued by each state.
	always_comb begin
		node_rd = '0;
		node_wr = '0;
		bkt_rd  = '0;
		bkt_wr  = '0;
		case (state_q)
			ST_CLR: begin
				node_wr.we_key  = 1'b1;
				node_wr.we_prev = 1'b1;
				node_wr.we_next = 1'b1;
				node_wr.we_pres = 1'b1;
				node_wr.addr    = b_q[NW-1:0];
				node_wr.data.prev = bmpq_pkg::NIL;
				node_wr.data.next = bmpq_pkg::NIL;
				bkt_wr.we_head  = 1'b1;
				bkt_wr.we_cnt   = 1'b1;
				bkt_wr.addr     = b_q[NW-1:0];
				bkt_wr.data.head = bmpq_pkg::NIL;
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					if (in_act == bmpq_pkg::ACT_POP) begin
						bkt_rd.en   = q_nonempty;
						bkt_rd.addr = low_q[NW-1:0];
					end else begin
						node_rd.en   = n_ok;
						node_rd.addr = in_node;
					end
				end
			end
			ST_NCHK: begin
				if (node_rdata.present && op_q != bmpq_pkg::ACT_INSERT &&
						op_q != bmpq_pkg::ACT_QUERY) begin
					node_wr.we_prev = 1'b1;
					node_wr.we_next = 1'b1;
					node_wr.we_pres = 1'b1;
					node_wr.addr    = n_q;
					node_wr.data.prev = bmpq_pkg::NIL;
					node_wr.data.next = bmpq_pkg::NIL;
					bkt_rd.en   = 1'b1;
					bkt_rd.addr = node_rdata.key;
				end
			end
			ST_U2: begin
				node_wr.we_next   = (p_q != bmpq_pkg::NIL);
				node_wr.addr      = p_q[NW-1:0];
				node_wr.data.next = x_q;
				bkt_wr.we_head    = (p_q == bmpq_pkg::NIL);
				bkt_wr.we_cnt     = 1'b1;
				bkt_wr.addr       = uk_q;
				bkt_wr.data.head  = x_q;
				bkt_wr.data.cnt   = newcnt;
			end
			ST_U3: begin
				node_wr.we_prev   = (x_q != bmpq_pkg::NIL);
				node_wr.addr      = x_q[NW-1:0];
				node_wr.data.prev = p_q;
			end
			ST_SRD: begin
				bkt_rd.en   = (b_q != bmpq_pkg::NIL);
				bkt_rd.addr = b_q[NW-1:0];
			end
			ST_L0: begin
				bkt_rd.en   = 1'b1;
				bkt_rd.addr = kin_q;
			end
			ST_L1: begin
				node_wr.we_key  = 1'b1;
				node_wr.we_prev = 1'b1;
				node_wr.we_next = 1'b1;
				node_wr.we_pres = 1'b1;
				node_wr.addr    = n_q;
				node_wr.data.key     = kin_q;
				node_wr.data.prev    = bmpq_pkg::NIL;
				node_wr.data.next    = bkt_rdata.head;
				node_wr.data.present = 1'b1;
				bkt_wr.we_head   = 1'b1;
				bkt_wr.we_cnt    = 1'b1;
				bkt_wr.addr      = kin_q;
				bkt_wr.data.head = {1'b0, n_q};
				bkt_wr.data.cnt  = bkt_rdata.cnt + LW'(1);
			end
			ST_L2: begin
				node_wr.we_prev   = 1'b1;
				node_wr.addr      = h_q[NW-1:0];
				node_wr.data.prev = {1'b0, n_q};
			end
			ST_PHD: begin
				node_rd.en   = (bkt_rdata.head != bmpq_pkg::NIL);
				node_rd.addr = bkt_rdata.head[NW-1:0];
			end
			ST_FIN0: begin
				bkt_rd.en   = q_nonempty;
				bkt_rd.addr = low_q[NW-1:0];
			end
			ST_FIN1: begin
				node_rd.en   = (bkt_rdata.head != bmpq_pkg::NIL);
				node_rd.addr = bkt_rdata.head[NW-1:0];
			end
			default: begin
			end
		endcase
	end

	// Sequencer and bookkeeping registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLR;
			b_q      <= '0;
			total_q  <= '0;
			low_q    <= bmpq_pkg::NIL;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && m_tready && state_q != ST_FOUT) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					b_q <= b_q + LW'(1);
					if (b_q == LW'(bmpq_pkg::NODES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q     <= in_act;
						n_q      <= in_node;
						kin_q    <= in_key;
						status_q <= 1'b0;
						rnode_q  <= '0;
						rkey_q   <= '0;
						qkey_q   <= '0;
						case (in_act)
							bmpq_pkg::ACT_INSERT, bmpq_pkg::ACT_CHANGE: begin
								if (n_ok && k_ok) begin
									state_q <= ST_NCHK;
								end else begin
									status_q <= 1'b1;
									state_q  <= ST_FIN0;
								end
							end
							bmpq_pkg::ACT_REMOVE, bmpq_pkg::ACT_QUERY: begin
								if (n_ok) begin
									state_q <= ST_NCHK;
								end else begin
									status_q <= 1'b1;
									state_q  <= ST_FIN0;
								end
							end
							bmpq_pkg::ACT_POP: begin
								if (q_nonempty) begin
									state_q <= ST_PHD;
								end else begin
									status_q <= 1'b1;
									state_q  <= ST_FIN0;
								end
							end
							default: begin
								status_q <= 1'b1;
								state_q  <= ST_FIN0;
							end
						endcase
					end
				end
				ST_PHD: begin
					if (bkt_rdata.head == bmpq_pkg::NIL) begin
						status_q <= 1'b1;
						state_q  <= ST_FIN0;
					end else begin
						rnode_q <= bkt_rdata.head[NW-1:0];
						n_q     <= bkt_rdata.head[NW-1:0];
						state_q <= ST_NCHK;
					end
				end
				ST_NCHK: begin
					// Node entry is back: check presence and, for remove, change and pop, start the unlink.
					uk_q <= node_rdata.key;
					p_q  <= node_rdata.prev;
					x_q  <= node_rdata.next;
					case (op_q)
						bmpq_pkg::ACT_INSERT: begin
							if (node_rdata.present) begin
								status_q <= 1'b1;
								state_q  <= ST_FIN0;
							end else begin
								state_q <= ST_L0;
							end
						end
						bmpq_pkg::ACT_QUERY: begin
							qkey_q  <= node_rdata.key;
							state_q <= ST_FIN0;
						end
						bmpq_pkg::ACT_POP: begin
							rkey_q  <= node_rdata.key;
							state_q <= ST_U2;
						end
						bmpq_pkg::ACT_REMOVE: begin
							if (node_rdata.present) begin
								state_q <= ST_U2;
							end else begin
								status_q <= 1'b1;
								state_q  <= ST_FIN0;
							end
						end
						default: begin
							state_q <= node_rdata.present ? ST_U2 : ST_FIN0;
						end
					endcase
				end
				ST_U2: begin
					if (total_q != '0) begin
						total_q <= total_q - LW'(1);
					end
					cnt0_q  <= (newcnt == '0);
					state_q <= ST_U3;
				end
				ST_U3: begin
					// Keep the lowest bucket right; scan upward if it emptied.
					if (total_q == '0) begin
						low_q   <= bmpq_pkg::NIL;
						state_q <= (op_q == bmpq_pkg::ACT_CHANGE) ? ST_L0 : ST_FIN0;
					end else if ({1'b0, uk_q} == low_q && cnt0_q) begin
						b_q     <= {1'b0, uk_q} + LW'(1);
						state_q <= ST_SRD;
					end else begin
						state_q <= (op_q == bmpq_pkg::ACT_CHANGE) ? ST_L0 : ST_FIN0;
					end
				end
				ST_SRD: begin
					if (b_q == bmpq_pkg::NIL) begin
						low_q   <= bmpq_pkg::NIL;
						state_q <= (op_q == bmpq_pkg::ACT_CHANGE) ? ST_L0 : ST_FIN0;
					end else begin
						state_q <= ST_SCK;
					end
				end
				ST_SCK: begin
					if (bkt_rdata.cnt != '0) begin
						low_q   <= b_q;
						state_q <= (op_q == bmpq_pkg::ACT_CHANGE) ? ST_L0 : ST_FIN0;
					end else begin
						b_q     <= b_q + LW'(1);
						state_q <= ST_SRD;
					end
				end
				ST_L0: begin
					state_q <= ST_L1;
				end
				ST_L1: begin
					h_q     <= bkt_rdata.head;
					total_q <= total_q + LW'(1);
					if ({1'b0, kin_q} < low_q) begin
						low_q <= {1'b0, kin_q};
					end
					state_q <= (bkt_rdata.head != bmpq_pkg::NIL) ? ST_L2 : ST_FIN0;
				end
				ST_L2: begin
					state_q <= ST_FIN0;
				end
				ST_FIN0: begin
					tval_q  <= 1'b0;
					tnode_q <= '0;
					tkey_q  <= '0;
					state_q <= q_nonempty ? ST_FIN1 : ST_FOUT;
				end
				ST_FIN1: begin
					if (bkt_rdata.head != bmpq_pkg::NIL) begin
						tval_q  <= 1'b1;
						tnode_q <= bkt_rdata.head[NW-1:0];
						state_q <= ST_FIN2;
					end else begin
						state_q <= ST_FOUT;
					end
				end
				ST_FIN2: begin
					tkey_q  <= node_rdata.key;
					state_q <= ST_FOUT;
				end
				ST_FOUT: begin
					// Load the result beat once the output register is free.
					if (!ovalid_q || m_tready) begin
						out_q    <= {1'b0, total_q, tkey_q, tnode_q, tval_q,
								qkey_q, rkey_q, rnode_q, status_q};
						ovalid_q <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The node count never exceeds the number of nodes.
	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= LW'(bmpq_pkg::NODES))
		else $error("node count out of range");

	// Between items, an empty queue and an empty lowest-bucket marker go together.
	a_low_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ((total_q == '0) == (low_q == bmpq_pkg::NIL)))
		else $error("lowest bucket disagrees with node count");

	// An accepted beat always starts work.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q != ST_IDLE))
		else $error("accepted beat not processed");

endmodule

@@ src/bucket_min_priority_queue_top.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Width  Content
// s_*       in   24     action, node_index, key_value
// m_*       out  64     status, removed_node, removed_key, queried_key,
//                       top_valid, top_node, top_key, node_count
//
// One item at a time; an action that empties the lowest bucket also reads buckets
// upward in a scan, one bucket at a time through the single read port of each
// memory.
// After reset a clearing pass over all 1024 node and bucket entries runs before the first beat is taken.
// A stalled result is held in the output register; the next beat is taken
// meanwhile, and its result waits until that register is free.

module bucket_min_priority_queue_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// action[2:0], node_index[12:3], key_value[22:13], zero pad
	input  logic [23:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[0], removed_node[10:1], removed_key[20:11], queried_key[30:21],
	// top_valid[31], top_node[41:32], top_key[51:42], node_count[62:52], pad
	output logic [63:0] m_tdata
);

	bmpq_pkg::mem_rd_t   node_rd, bkt_rd;
	bmpq_pkg::node_wr_t  node_wr;
	bmpq_pkg::bkt_wr_t   bkt_wr;
	bmpq_pkg::node_ent_t node_rdata;
	bmpq_pkg::bkt_ent_t  bkt_rdata;

	bmpq_node_mem u_node_mem (
		.clk   (clk),
		.rd    (node_rd),
		.wr    (node_wr),
		.rdata (node_rdata)
	);

	bmpq_bkt_mem u_bkt_mem (
		.clk   (clk),
		.rd    (bkt_rd),
		.wr    (bkt_wr),
		.rdata (bkt_rdata)
	);

	bmpq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.node_rd    (node_rd),
		.node_wr    (node_wr),
		.node_rdata (node_rdata),
		.bkt_rd     (bkt_rd),
		.bkt_wr     (bkt_wr),
		.bkt_rdata  (bkt_rdata)
	);

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

	localparam int LIMIT_CYCLES = 20000000;
	localparam int RANDOM_ITEMS = 1330;

	// Fields of one result beat.
	typedef struct packed {
		logic [10:0] count;
		logic [9:0]  top_key;
		logic [9:0]  top_node;
		logic        top_valid;
		logic [9:0]  qkey;
		logic [9:0]  rkey;
		logic [9:0]  rnode;
		logic        status;
	} queue_result_t;

	// One directed row: action, node, key, and an optional typed-in result.
	typedef struct {
		logic [2:0]    act;
		logic [9:0]    node;
		logic [9:0]    key;
		bit            fixed;
		queue_result_t res;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;

	bucket_min_priority_queue_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// Shadow copy of the queue.
	logic [9:0]  key_of   [bmpq_pkg::NODES];
	logic [10:0] prev_of  [bmpq_pkg::NODES];
	logic [10:0] next_of  [bmpq_pkg::NODES];
	bit          held     [bmpq_pkg::NODES];
	bit          written  [bmpq_pkg::NODES];
	logic [10:0] head_of  [bmpq_pkg::NODES];
	int          bucket_n [bmpq_pkg::NODES];
	int          held_total;
	int          min_bucket;

	queue_result_t pending_results[$];
	int  mismatches;
	int  results_seen;
	int  pops_done;
	int  illegal_seen;
	longint cycle_count;
	bit  quiet_tail;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > LIMIT_CYCLES) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("status: fail");
				$finish;
			end
		end
	end

	function automatic void shadow_link(input int n, input int k);
		key_of[n] = k[9:0];
		prev_of[n] = bmpq_pkg::NIL;
		next_of[n] = head_of[k];
		if (head_of[k] != bmpq_pkg::NIL)
			prev_of[head_of[k]] = n[10:0];
		head_of[k] = n[10:0];
		held[n] = 1;
		written[n] = 1;
		bucket_n[k]++;
		held_total++;
		if (k < min_bucket)
			min_bucket = k;
	endfunction

	function automatic void shadow_unlink(input int n);
		int k;
		int b;
		logic [10:0] p;
		logic [10:0] x;
		k = key_of[n];
		p = prev_of[n];
		x = next_of[n];
		if (p != bmpq_pkg::NIL)
			next_of[p] = x;
		else
			head_of[k] = x;
		if (x != bmpq_pkg::NIL)
			prev_of[x] = p;
		held[n] = 0;
		bucket_n[k]--;
		held_total--;
		if (held_total == 0) begin
			min_bucket = bmpq_pkg::NODES;
		end else if (k == min_bucket && bucket_n[k] == 0) begin
			b = k;
			while (b < bmpq_pkg::NODES && bucket_n[b] == 0)
				b++;
			min_bucket = b;
		end
	endfunction

	// Apply one action to the shadow queue and return the result it should give.
	function automatic queue_result_t predict_queue(input logic [2:0] act,
			input logic [9:0] node, input logic [9:0] key);
		queue_result_t r;
		int h;
		r = '0;
		case (act)
			bmpq_pkg::ACT_INSERT: begin
				if (held[node]) r.status = 1;
				else shadow_link(node, key);
			end
			bmpq_pkg::ACT_REMOVE: begin
				if (!held[node]) r.status = 1;
				else shadow_unlink(node);
			end
			bmpq_pkg::ACT_CHANGE: begin
				if (held[node]) begin
					shadow_unlink(node);
					shadow_link(node, key);
				end
			end
			bmpq_pkg::ACT_POP: begin
				if (held_total == 0) begin
					r.status = 1;
				end else begin
					h = head_of[min_bucket];
					r.rnode = h[9:0];
					r.rkey = key_of[h];
					shadow_unlink(h);
				end
			end
			bmpq_pkg::ACT_QUERY: r.qkey = key_of[node];
			default: r.status = 1;
		endcase
		if (held_total > 0) begin
			r.top_valid = 1;
			r.top_node = head_of[min_bucket][9:0];
			r.top_key = key_of[head_of[min_bucket]];
		end
		r.count = held_total[10:0];
		return r;
	endfunction

	// Send one beat, at times with a random burst of idle cycles before it.
	task automatic send_beat(input logic [2:0] act, input logic [9:0] node,
			input logic [9:0] key);
		int gap;
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, key, node, act};
		do @(posedge clk); while (!s_tready);
	endtask

	// Submit an action: predict, queue the expectation, then drive it.
	task automatic submit(input logic [2:0] act, input logic [9:0] node,
			input logic [9:0] key, input bit fixed, input queue_result_t res);
		queue_result_t p;
		p = predict_queue(act, node, key);
		if (p.status) illegal_seen++;
		if (act == bmpq_pkg::ACT_POP && !p.status) pops_done++;
		pending_results.push_back(fixed ? res : p);
		send_beat(act, node, key);
	endtask

	// Result side: random stalls and field-by-field compare.
	initial begin
		queue_result_t got;
		queue_result_t want;
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!quiet_tail && $urandom_range(0, 3) == 0) begin
				stall = $urandom_range(1, 16);
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = queue_result_t'(m_tdata[62:0]);
				results_seen++;
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat %h", m_tdata);
				end else begin
					want = pending_results.pop_front();
					if (got !== want || m_tdata[63] !== 1'b0) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result %0d: expected st=%0d rm=%0d/%0d q=%0d top=%0d %0d/%0d cnt=%0d, got st=%0d rm=%0d/%0d q=%0d top=%0d %0d/%0d cnt=%0d",
								results_seen, want.status, want.rnode, want.rkey, want.qkey,
								want.top_valid, want.top_node, want.top_key, want.count,
								got.status, got.rnode, got.rkey, got.qkey,
								got.top_valid, got.top_node, got.top_key, got.count);
					end
				end
			end
		end
	end

	// Pick a node that has been written, for queries; after 64 misses, node 0.
	function automatic logic [9:0] pick_written();
		int n;
		repeat (64) begin
			n = $urandom_range(0, bmpq_pkg::NODES - 1);
			if (written[n]) return n[9:0];
		end
		return 10'd0;
	endfunction

	initial begin
		dir_row_t table_rows[$];
		dir_row_t row;
		queue_result_t z;
		logic [2:0] act;
		logic [9:0] node;
		logic [9:0] key;
		int sel;
		int i;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		quiet_tail = 0;
		mismatches = 0;
		results_seen = 0;
		pops_done = 0;
		illegal_seen = 0;
		held_total = 0;
		min_bucket = bmpq_pkg::NODES;
		for (i = 0; i < bmpq_pkg::NODES; i++) begin
			key_of[i] = '0;
			prev_of[i] = bmpq_pkg::NIL;
			next_of[i] = bmpq_pkg::NIL;
			held[i] = 0;
			written[i] = 0;
			head_of[i] = bmpq_pkg::NIL;
			bucket_n[i] = 0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed rows; fixed results only where obvious.
		z = '0;
		z.status = 1;
		table_rows.push_back('{bmpq_pkg::ACT_POP, 10'd0, 10'd0, 1, z});
		table_rows.push_back('{bmpq_pkg::ACT_REMOVE, 10'd5, 10'd0, 1, z});
		z = '0;
		table_rows.push_back('{bmpq_pkg::ACT_CHANGE, 10'd5, 10'd9, 1, z});
		z = '0; z.top_valid = 1; z.top_node = 10'd1023; z.top_key = 10'd1023; z.count = 1;
		table_rows.push_back('{bmpq_pkg::ACT_INSERT, 10'd1023, 10'd1023, 1, z});
		z.status = 1;
		table_rows.push_back('{bmpq_pkg::ACT_INSERT, 10'd1023, 10'd3, 1, z});
		z = '0; z.top_valid = 1; z.count = 2;
		table_rows.push_back('{bmpq_pkg::ACT_INSERT, 10'd0, 10'd0, 1, z});
		table_rows.push_back('{bmpq_pkg::ACT_INSERT, 10'd7, 10'd0, 0, z});
		table_rows.push_back('{bmpq_pkg::ACT_INSERT, 10'd8, 10'd0, 0, z});
		table_rows.push_back('{bmpq_pkg::ACT_REMOVE, 10'd7, 10'd0, 0, z});
		table_rows.push_back('{bmpq_pkg::ACT_CHANGE, 10'd8, 10'd0, 0, z});
		table_rows.push_back('{bmpq_pkg::ACT_CHANGE, 10'd0, 10'd500, 0, z});
		table_rows.push_back('{bmpq_pkg::ACT_QUERY, 10'd0, 10'd0, 0, z});
		table_rows.push_back('{bmpq_pkg::ACT_QUERY, 10'd7, 10'd0, 0, z});
		table_rows.push_back('{3'd5, 10'd1, 10'd1, 0, z});
		table_rows.push_back('{3'd6, 10'd1, 10'd1, 0, z});
		table_rows.push_back('{3'd7, 10'd1023, 10'd1023, 0, z});
		table_rows.push_back('{bmpq_pkg::ACT_POP, 10'd0, 10'd0, 0, z});
		table_rows.push_back('{bmpq_pkg::ACT_POP, 10'd0, 10'd0, 0, z});
		table_rows.push_back('{bmpq_pkg::ACT_POP, 10'd0, 10'd0, 0, z});
		z = '0; z.status = 1;
		table_rows.push_back('{bmpq_pkg::ACT_POP, 10'd0, 10'd0, 1, z});
		z = '0; z.qkey = 10'd1023;
		table_rows.push_back('{bmpq_pkg::ACT_QUERY, 10'd1023, 10'd0, 1, z});
		foreach (table_rows[j]) begin
			row = table_rows[j];
			submit(row.act, row.node, row.key, row.fixed, row.res);
		end

		// Random part: mostly legal actions on a small node pool, some noise.
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS - 150) quiet_tail = 1;
			sel = $urandom_range(0, 99);
			node = (sel < 85) ? 10'($urandom_range(0, 63))
				: 10'($urandom_range(0, bmpq_pkg::NODES - 1));
			key = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, bmpq_pkg::NODES - 1))
				: 10'($urandom_range(0, 40));
			sel = $urandom_range(0, 99);
			if (sel < 35) act = bmpq_pkg::ACT_INSERT;
			else if (sel < 50) act = bmpq_pkg::ACT_REMOVE;
			else if (sel < 65) act = bmpq_pkg::ACT_CHANGE;
			else if (sel < 88) act = bmpq_pkg::ACT_POP;
			else if (sel < 96) act = bmpq_pkg::ACT_QUERY;
			else act = 3'($urandom_range(5, 7));
			if (act == bmpq_pkg::ACT_QUERY && !written[node])
				node = pick_written();
			submit(act, node, key, 0, z);
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);

		$display("ran %0d actions, %0d results checked, %0d pops, %0d illegal actions",
			RANDOM_ITEMS + table_rows.size(), results_seen, pops_done, illegal_seen);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("status: fail");
		end
		$finish;
	end

endmodule
